// ===== src/aes_pkg.sv =====
// ---------------------------------------------------------------------------
// AES package
// Shared types, constants and byte-level functions for the AES block.
// ---------------------------------------------------------------------------
package aes_pkg;

    localparam int MaxRoundsDefault = 12;
    localparam int KeyWidth         = 64;
    localparam int CfgIndexWidth    = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_KEY_WORD_0    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_KEY_WORD_1    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_KEY_WORD_2    = 2'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_KEY_SIZE_MODE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYEXP,
        ST_INVKEY,
        ST_ROUND
    } aes_state_t;

    // One-round request to the shared round unit
    typedef struct packed {
        logic decrypt;
        logic first;
        logic last;
    } aes_round_ctl_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] a;
        p = 8'h00;
        a = a_in;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = xtime(a);
        end
        gf_mul = p;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] base;
        logic [7:0] e;
        r = 8'h01;
        base = x;
        e = 8'd254;
        for (int i = 0; i < 8; i++)
        begin
            if (e[i])
                r = gf_mul(r, base);
            base = gf_mul(base, base);
        end
        gf_inv = r;
    endfunction

    function automatic logic [7:0] rot8(input logic [7:0] x, input int n);
        rot8 = (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] b;
        b = gf_inv(x);
        sbox_calc = b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(input logic [7:0] x);
        inv_sbox_calc = gf_inv(rot8(x, 1) ^ rot8(x, 3) ^ rot8(x, 6) ^ 8'h05);
    endfunction

    // Constant tables built at elaboration
    typedef logic [7:0] sbox_t [256];

    function automatic sbox_t make_sbox(input logic inverse);
        sbox_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
        end
        make_sbox = t;
    endfunction

    localparam sbox_t SBOX     = make_sbox(1'b0);
    localparam sbox_t INV_SBOX = make_sbox(1'b1);

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inverse);
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        logic [7:0] m0;
        logic [7:0] m1;
        logic [7:0] m2;
        logic [7:0] m3;
        a0 = c[31:24];
        a1 = c[23:16];
        a2 = c[15:8];
        a3 = c[7:0];
        m0 = inverse ? 8'd14 : 8'd2;
        m1 = inverse ? 8'd11 : 8'd3;
        m2 = inverse ? 8'd13 : 8'd1;
        m3 = inverse ? 8'd9  : 8'd1;
        mix_col = {gf_mul(a0, m0) ^ gf_mul(a1, m1) ^ gf_mul(a2, m2) ^ gf_mul(a3, m3),
                   gf_mul(a0, m3) ^ gf_mul(a1, m0) ^ gf_mul(a2, m1) ^ gf_mul(a3, m2),
                   gf_mul(a0, m2) ^ gf_mul(a1, m3) ^ gf_mul(a2, m0) ^ gf_mul(a3, m1),
                   gf_mul(a0, m1) ^ gf_mul(a1, m2) ^ gf_mul(a2, m3) ^ gf_mul(a3, m0)};
    endfunction

    function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inverse);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
        begin
            o[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inverse);
        end
        mix_state = o;
    endfunction

endpackage

// ===== src/aes_ram.sv =====
// ---------------------------------------------------------------------------
// AES generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== src/aes_round.sv =====
// ---------------------------------------------------------------------------
// AES round unit
// One full cipher or inverse-cipher round on a 128-bit state per call.
// ---------------------------------------------------------------------------
module aes_round
    import aes_pkg::*;
(
    input  logic [127:0]   state_in,
    input  logic [127:0]   round_key,
    input  aes_round_ctl_t ctl,
    output logic [127:0]   state_out
);

    logic [127:0] shifted;
    logic [127:0] mixed;

    // Byte b = row r + 4*col c sits at bits 127-8*b
    always_comb
    begin
        shifted = '0;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (!ctl.decrypt)
                    shifted[127-8*(r+4*c) -: 8] = SBOX[state_in[127-8*(r+4*((c+r)%4)) -: 8]];
                else
                    shifted[127-8*(r+4*((c+r)%4)) -: 8] = INV_SBOX[state_in[127-8*(r+4*c) -: 8]];
            end
        end
        mixed = ctl.last ? shifted : mix_state(shifted, ctl.decrypt);
        state_out = (ctl.first ? state_in : mixed) ^ round_key;
    end

endmodule

// ===== src/aes_keyexp.sv =====
// ---------------------------------------------------------------------------
// AES key expansion step
// Produces one 64-bit pair of schedule words per call from the history.
// ---------------------------------------------------------------------------
module aes_keyexp
    import aes_pkg::*;
(
    input  logic [191:0] hist,      // last six words, w[i-6] in the top bits
    input  logic         long_key,
    input  logic [7:0]   rcon,
    input  logic         use_rot,   // first word of this pair starts a key group
    input  logic         use_sub,   // second word starts a group (192-bit only)
    output logic [63:0]  words
);

    logic [31:0] prev;
    logic [31:0] t0;
    logic [31:0] w0;
    logic [31:0] t1;
    logic [31:0] w1;
    logic [31:0] far0;
    logic [31:0] far1;

    function automatic logic [31:0] sub_rot(input logic [31:0] t, input logic [7:0] rc);
        logic [31:0] r;
        r = {t[23:0], t[31:24]};
        sub_rot = {SBOX[r[31:24]] ^ rc, SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
    endfunction

    always_comb
    begin
        prev = hist[31:0];
        far0 = long_key ? hist[191:160] : hist[127:96];
        far1 = long_key ? hist[159:128] : hist[95:64];
        t0 = use_rot ? sub_rot(prev, rcon) : prev;
        w0 = far0 ^ t0;
        t1 = use_sub ? sub_rot(w0, rcon) : w0;
        w1 = far1 ^ t1;
        words = {w0, w1};
    end

endmodule

// ===== src/aes_block_cipher_128_192_top.sv =====
// ---------------------------------------------------------------------------
// AES block cipher, 128/192-bit keys
// Iterative AES core with one shared round unit and stored round keys.
// ---------------------------------------------------------------------------
// Usage:
//   Configuration: write cfg_we/cfg_index/cfg_data while idle. Index 0..2 are
//   key words 0..2, index 3 the key size (0: 128-bit, 1: 192-bit). Any write
//   marks the key schedule stale.
//   Input stream s_axis: tdata = {block_lo, block_hi}, tuser = action
//   (0 encrypt, 1 decrypt). Output stream m_axis: tdata = {result_lo,
//   result_hi}.
//   Timing: on the first block after reset or a key write the schedule is
//   rebuilt: key expansion writes the encryption schedule, then the inverse
//   schedule is written. Rounds are paced by the 64-bit round-key RAM port:
//   a round key is two reads, and the round unit fires once both halves
//   are read.
//   The block works on one transfer at a time. A stalled receiver holds the
//   result in the output register; the next block is still taken and waits
//   in its final round until that register is free, so s_axis_tready drops.
//   Reset clears control state; the key registers return to zero.
// ---------------------------------------------------------------------------
module aes_block_cipher_128_192_top
    import aes_pkg::*;
#(
    parameter int MAX_ROUNDS = MaxRoundsDefault
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [KeyWidth-1:0]      cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [127:0]             s_axis_tdata,   // block_lo, block_hi
    input  logic                     s_axis_tuser,   // action
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [127:0]             m_axis_tdata    // result_lo, result_hi
);

    localparam int Entries = 2 * (MAX_ROUNDS + 1);
    localparam int AW      = $clog2(Entries);

    // Configuration registers
    logic [63:0] key0_reg;
    logic [63:0] key1_reg;
    logic [63:0] key2_reg;
    logic        mode_reg;
    logic        ready_sched_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_WORD_0:    key0_reg <= cfg_data;
                CFG_KEY_WORD_1:    key1_reg <= cfg_data;
                CFG_KEY_WORD_2:    key2_reg <= cfg_data;
                CFG_KEY_SIZE_MODE: mode_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    logic        long_key;
    logic [AW:0] last_entry;   // index of final schedule entry, 2*Nr+1
    assign long_key   = mode_reg && (MAX_ROUNDS >= 12);
    assign last_entry = long_key ? (AW+1)'(25) : (AW+1)'(21);

    // Sequencer state
    aes_state_t   state_reg, state_next;
    logic [AW:0]  cnt_reg, cnt_next;
    logic [191:0] hist_reg, hist_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [1:0]   grp_reg, grp_next;      // position within key group
    logic [127:0] st_reg, st_next;
    logic [63:0]  khalf_reg, khalf_next;
    logic         dec_reg, dec_next;
    logic         valid_reg, valid_next;
    logic [127:0] out_reg, out_next;
    logic         ready_next;

    // RAM ports
    logic          e_we;
    logic          d_we;
    logic [AW-1:0] e_waddr;
    logic [AW-1:0] d_waddr;
    logic [63:0]   e_wdata;
    logic [63:0]   d_wdata;
    logic [AW-1:0] e_raddr;
    logic [AW-1:0] d_raddr;
    logic [63:0]   e_rdata;
    logic [63:0]   d_rdata;

    aes_ram #(.WIDTH(64), .DEPTH(Entries)) u_enc_ram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    aes_ram #(.WIDTH(64), .DEPTH(Entries)) u_dec_ram (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    // Key expansion step
    logic        use_rot;
    logic        use_sub;
    logic [63:0] ks_words;

    aes_keyexp u_keyexp (
        .hist(hist_reg), .long_key(long_key), .rcon(rcon_reg),
        .use_rot(use_rot), .use_sub(use_sub), .words(ks_words)
    );

    // Round unit for cipher and inverse-cipher rounds
    aes_round_ctl_t rctl;
    logic [127:0]   r_in;
    logic [127:0]   r_key;
    logic [127:0]   r_out;
    logic [127:0]   invk;

    aes_round u_round (
        .state_in(r_in), .round_key(r_key), .ctl(rctl), .state_out(r_out)
    );

    // InvMixColumns on a round key for the equivalent inverse schedule
    assign invk = mix_state({khalf_reg, e_rdata}, 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            valid_reg       <= 1'b0;
            ready_sched_reg <= 1'b0;
            rcon_reg        <= 8'h01;
            grp_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            valid_reg       <= valid_next;
            ready_sched_reg <= cfg_we ? 1'b0 : ready_next;
            rcon_reg        <= rcon_next;
            grp_reg         <= grp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg  <= hist_next;
        st_reg    <= st_next;
        khalf_reg <= khalf_next;
        dec_reg   <= dec_next;
        out_reg   <= out_next;
    end

    logic [AW:0]   rounds2;   // 2*Nr
    logic [AW:0]   src;
    assign rounds2 = last_entry - (AW+1)'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hist_next  = hist_reg;
        rcon_next  = rcon_reg;
        grp_next   = grp_reg;
        st_next    = st_reg;
        khalf_next = khalf_reg;
        dec_next   = dec_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        ready_next = ready_sched_reg;
        e_we = 1'b0;
        d_we = 1'b0;
        e_waddr = cnt_reg[AW-1:0];
        d_waddr = cnt_reg[AW-1:0];
        e_wdata = '0;
        d_wdata = '0;
        e_raddr = cnt_reg[AW-1:0];
        d_raddr = cnt_reg[AW-1:0];
        use_rot = 1'b0;
        use_sub = 1'b0;
        rctl = '{decrypt: dec_reg, first: 1'b0, last: 1'b0};
        r_in  = st_reg;
        r_key = {khalf_reg, dec_reg ? d_rdata : e_rdata};
        src   = '0;
        s_axis_tready = 1'b0;

        if (valid_reg && m_axis_tready)
            valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // Take a block even while a result waits in the output register
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    st_next  = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                    dec_next = s_axis_tuser;
                    cnt_next = '0;
                    if (ready_sched_reg)
                        state_next = ST_ROUND;
                    else
                    begin
                        state_next = ST_KEYEXP;
                        hist_next  = {key0_reg, key1_reg, key2_reg};
                        rcon_next  = 8'h01;
                        grp_next   = '0;
                    end
                end
            end

            ST_KEYEXP:
            begin
                // Entries 0..2 (128: 0..1) come from the key; then one pair a cycle
                e_we = 1'b1;
                if (long_key ? (cnt_reg < (AW+1)'(3)) : (cnt_reg < (AW+1)'(2)))
                begin
                    e_wdata = long_key ? hist_reg[191-64*cnt_reg[1:0] -: 64]
                                       : hist_reg[191-64*cnt_reg[1:0] -: 64];
                    if (cnt_reg == (long_key ? (AW+1)'(2) : (AW+1)'(1)))
                    begin
                        // Align history so hist[31:0] is the newest word
                        if (!long_key)
                            hist_next = {64'h0, hist_reg[191:64]};
                    end
                end
                else
                begin
                    if (long_key)
                    begin
                        use_rot = (grp_reg == 2'd0);
                        use_sub = 1'b0;
                        grp_next = (grp_reg == 2'd2) ? 2'd0 : grp_reg + 2'd1;
                    end
                    else
                    begin
                        use_rot = !grp_reg[0];
                        grp_next = {1'b0, ~grp_reg[0]};
                    end
                    if (use_rot)
                        rcon_next = xtime(rcon_reg);
                    e_wdata   = ks_words;
                    hist_next = {hist_reg[127:0], ks_words};
                end
                cnt_next = cnt_reg + (AW+1)'(1);
                if (cnt_reg == last_entry)
                begin
                    state_next = ST_INVKEY;
                    cnt_next   = '0;
                end
            end

            ST_INVKEY:
            begin
                // Write the inverse schedule pair by pair; enc entries are read ahead
                // of their use (registered RAM read). dec round r = enc round Nr-r
                src = rounds2 - {cnt_reg[AW:1], 1'b0};
                e_raddr = cnt_reg[0] ? AW'(src + (AW+1)'(1)) : src[AW-1:0];
                if (cnt_reg[0])
                    khalf_next = e_rdata;
                if (cnt_reg != '0 && !cnt_reg[0])
                begin
                    d_we    = 1'b1;
                    d_waddr = AW'(cnt_reg - (AW+1)'(2));
                    d_wdata = (cnt_reg == (AW+1)'(2) || cnt_reg == last_entry + (AW+1)'(1))
                              ? khalf_reg : invk[127:64];
                    khalf_next = (cnt_reg == (AW+1)'(2) ||
                                  cnt_reg == last_entry + (AW+1)'(1))
                                 ? e_rdata : invk[63:0];
                end
                if (cnt_reg != '0 && cnt_reg[0] && cnt_reg > (AW+1)'(2))
                begin
                    d_we       = 1'b1;
                    d_waddr    = AW'(cnt_reg - (AW+1)'(2));
                    d_wdata    = khalf_reg;
                    khalf_next = e_rdata;
                end
                cnt_next = cnt_reg + (AW+1)'(1);
                if (cnt_reg == last_entry + (AW+1)'(2))
                begin
                    state_next = ST_ROUND;
                    ready_next = 1'b1;
                    cnt_next   = '0;
                end
            end

            ST_ROUND:
            begin
                // Even count: read high half; odd: read low half; then apply
                e_raddr = cnt_reg[AW-1:0];
                d_raddr = cnt_reg[AW-1:0];
                if (cnt_reg != '0 && cnt_reg[0])
                    khalf_next = dec_reg ? d_rdata : e_rdata;
                if (cnt_reg != '0 && !cnt_reg[0])
                begin
                    rctl.first = (cnt_reg == (AW+1)'(2));
                    rctl.last  = (cnt_reg == last_entry + (AW+1)'(1));
                    st_next    = r_out;
                end
                cnt_next = cnt_reg + (AW+1)'(1);
                if (cnt_reg == last_entry + (AW+1)'(1))
                begin
                    // Re-read the low half so the round key holds while stalled
                    e_raddr = AW'(cnt_reg - (AW+1)'(1));
                    d_raddr = AW'(cnt_reg - (AW+1)'(1));
                    if (valid_reg && !m_axis_tready)
                    begin
                        // Hold the final round until the output register is free
                        st_next  = st_reg;
                        cnt_next = cnt_reg;
                    end
                    else
                    begin
                        out_next   = r_out;
                        valid_next = 1'b1;
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Byte order: block_hi is the first eight state bytes
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {out_reg[63:0], out_reg[127:64]};

endmodule
